// ===== rtl/fbcm_pkg.sv =====
// Shared command and status codes for the block chain manager.
`timescale 1ns / 1ps

package fbcm_pkg;

    typedef enum logic [2:0] {
        ACT_CREATE = 3'd0,
        ACT_REMOVE = 3'd1,
        ACT_ADD    = 3'd2,
        ACT_DELETE = 3'd3,
        ACT_NEXT   = 3'd4,
        ACT_FIRST  = 3'd5
    } action_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_FILE   = 3'd1,
        ST_EXISTS    = 3'd2,
        ST_NO_ROOM   = 3'd3,
        ST_NOT_EMPTY = 3'd4,
        ST_DISK_FULL = 3'd5,
        ST_NOT_IN    = 3'd6
    } status_t;

endpackage

// ===== rtl/fbcm_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module fbcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/fat_block_chain_manager_unit.sv =====
// Top level of the file allocation table block chain manager.
`timescale 1ns / 1ps
// Usage
// Requests arrive on the input channel (in_valid/in_ready) carrying action,
// file_key and block_index; each request yields exactly one result on the
// output channel (out_valid/out_ready) carrying status and result_block.
// The link table sits in a RAM with a registered read; the root directory is
// held in registers and searched in parallel when a request is taken.
// One request is worked on at a time. Create, remove, first block and
// errors found at dispatch go from dispatch straight to the result. Add
// block first takes a block off the free chain (a full disk ends there),
// clears it and then walks the file's chain to append it at the end. Next
// block and delete block walk the chain link by link to the given block;
// a block missing from the chain answers once the walk reaches the end.
// The chain walk through the RAM port sets the rate.
// After reset the block writes every entry of the initial link table
// (reserved entries and the free chain) and takes no request then.
// A finished result waits in an output register while the receiver stalls;
// the next request may be taken and worked on meanwhile, but its result is
// held back until the earlier one has been taken.

module fat_block_chain_manager_unit #(
    parameter int NUM_BLOCKS   = 256,
    parameter int ROOT_ENTRIES = 12,
    parameter int FAT_BLOCKS   = 11
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  action,
    input  logic [31:0] file_key,
    input  logic [7:0]  block_index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [7:0]  result_block
);

    import fbcm_pkg::*;

    localparam int BW    = $clog2(NUM_BLOCKS);
    localparam int RW    = (ROOT_ENTRIES > 1) ? $clog2(ROOT_ENTRIES) : 1;
    localparam int START = FAT_BLOCKS + 2;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_DISP, S_A_ALLOC, S_A_NXT, S_A_CLR, S_A_WALK,
        S_WALK, S_D_RDBLK, S_D_FREE, S_D_PUSH, S_OUT
    } state_t;

    state_t          state_reg;
    logic [BW-1:0]   init_cnt_reg;
    logic [31:0]     name_reg [ROOT_ENTRIES];
    logic [BW-1:0]   head_reg [ROOT_ENTRIES];
    logic [2:0]      action_reg;
    logic [31:0]     key_reg;
    logic [BW-1:0]   blk_reg;
    logic            blk_ok_reg;
    logic            found_reg;
    logic [RW-1:0]   fidx_reg;
    logic            empty_reg;
    logic [RW-1:0]   eidx_reg;
    logic [BW-1:0]   alloc_reg;
    logic [BW-1:0]   b_reg;
    logic [BW-1:0]   pred_reg;
    logic [BW:0]     steps_reg;
    logic [2:0]      st_reg;
    logic [BW-1:0]   res_reg;
    logic            out_valid_reg;
    logic [2:0]      status_reg;
    logic [7:0]      result_reg;

    logic            found_next;
    logic [RW-1:0]   fidx_next;
    logic            empty_next;
    logic [RW-1:0]   eidx_next;
    logic [BW-1:0]   head_cur;
    logic            chain_start_ok;
    logic            walk_live;

    logic            ram_we;
    logic [BW-1:0]   ram_waddr;
    logic [BW-1:0]   ram_wdata;
    logic [BW-1:0]   ram_raddr;
    logic [BW-1:0]   ram_rdata;

    function automatic logic [BW-1:0] init_value(input logic [BW-1:0] idx);
        logic [BW-1:0] val;
        if (idx == '0)
        begin
            val = (START < NUM_BLOCKS) ? BW'(START) : '0;
        end
        else if (32'(idx) < START)
        begin
            val = BW'(1);
        end
        else if (idx == BW'(NUM_BLOCKS - 1))
        begin
            val = '0;
        end
        else
        begin
            val = idx + BW'(1);
        end
        return val;
    endfunction

    fbcm_ram #(
        .WIDTH(BW),
        .DEPTH(NUM_BLOCKS)
    ) u_link_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_comb
    begin
        found_next = 1'b0;
        fidx_next  = '0;
        empty_next = 1'b0;
        eidx_next  = '0;
        for (int i = ROOT_ENTRIES - 1; i >= 0; i--)
        begin
            if (name_reg[i] == file_key && file_key != '0)
            begin
                found_next = 1'b1;
                fidx_next  = RW'(i);
            end
            if (name_reg[i] == '0)
            begin
                empty_next = 1'b1;
                eidx_next  = RW'(i);
            end
        end
    end

    assign head_cur       = head_reg[fidx_reg];
    assign chain_start_ok = blk_ok_reg && (blk_reg != '0) && (head_cur != '0);
    assign walk_live      = (steps_reg < (BW+1)'(NUM_BLOCKS));

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_raddr = '0;
        unique case (state_reg)
            S_INIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = init_cnt_reg;
                ram_wdata = init_value(init_cnt_reg);
            end
            S_DISP:
            begin
                ram_raddr = (head_cur == blk_reg) ? blk_reg : head_cur;
                if (action_reg == ACT_ADD)
                begin
                    ram_raddr = '0;
                end
            end
            S_A_ALLOC:
            begin
                ram_raddr = ram_rdata;
            end
            S_A_NXT:
            begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = ram_rdata;
            end
            S_A_CLR:
            begin
                ram_we    = 1'b1;
                ram_waddr = alloc_reg;
                ram_wdata = '0;
                ram_raddr = head_cur;
            end
            S_A_WALK:
            begin
                ram_raddr = ram_rdata;
                if (!(walk_live && ram_rdata != '0))
                begin
                    ram_we    = 1'b1;
                    ram_waddr = b_reg;
                    ram_wdata = alloc_reg;
                end
            end
            S_WALK:
            begin
                ram_raddr = ram_rdata;
            end
            S_D_RDBLK:
            begin
                ram_raddr = '0;
                if (action_reg == ACT_DELETE && pred_reg != '0)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pred_reg;
                    ram_wdata = ram_rdata;
                end
            end
            S_D_FREE:
            begin
                ram_we    = 1'b1;
                ram_waddr = blk_reg;
                ram_wdata = ram_rdata;
            end
            S_D_PUSH:
            begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = blk_reg;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            init_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < ROOT_ENTRIES; i++)
            begin
                name_reg[i] <= '0;
                head_reg[i] <= '0;
            end
        end
        else
        begin
            if (out_valid_reg && out_ready && state_reg != S_OUT)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_INIT:
                begin
                    init_cnt_reg <= init_cnt_reg + BW'(1);
                    if (init_cnt_reg == BW'(NUM_BLOCKS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        action_reg <= action;
                        key_reg    <= file_key;
                        blk_reg    <= BW'(block_index);
                        blk_ok_reg <= (32'(block_index) < NUM_BLOCKS);
                        found_reg  <= found_next;
                        fidx_reg   <= fidx_next;
                        empty_reg  <= empty_next;
                        eidx_reg   <= eidx_next;
                        state_reg  <= S_DISP;
                    end
                end
                S_DISP:
                begin
                    st_reg    <= ST_OK;
                    res_reg   <= '0;
                    steps_reg <= '0;
                    b_reg     <= head_cur;
                    pred_reg  <= '0;
                    state_reg <= S_OUT;
                    if (action_reg == ACT_CREATE)
                    begin
                        if (key_reg == '0)
                        begin
                            st_reg <= ST_NO_FILE;
                        end
                        else if (found_reg)
                        begin
                            st_reg <= ST_EXISTS;
                        end
                        else if (empty_reg)
                        begin
                            name_reg[eidx_reg] <= key_reg;
                            head_reg[eidx_reg] <= '0;
                        end
                        else
                        begin
                            st_reg <= ST_NO_ROOM;
                        end
                    end
                    else if (action_reg <= ACT_FIRST && !found_reg)
                    begin
                        st_reg <= ST_NO_FILE;
                    end
                    else
                    begin
                        unique case (action_reg)
                            ACT_REMOVE:
                            begin
                                if (head_cur != '0)
                                begin
                                    st_reg <= ST_NOT_EMPTY;
                                end
                                else
                                begin
                                    name_reg[fidx_reg] <= '0;
                                end
                            end
                            ACT_ADD:
                            begin
                                state_reg <= S_A_ALLOC;
                            end
                            ACT_DELETE, ACT_NEXT:
                            begin
                                if (!chain_start_ok)
                                begin
                                    st_reg <= ST_NOT_IN;
                                end
                                else if (head_cur == blk_reg)
                                begin
                                    state_reg <= S_D_RDBLK;
                                end
                                else
                                begin
                                    state_reg <= S_WALK;
                                end
                            end
                            ACT_FIRST:
                            begin
                                res_reg <= head_cur;
                            end
                            default:
                            begin
                                st_reg <= ST_OK;
                            end
                        endcase
                    end
                end
                S_A_ALLOC:
                begin
                    alloc_reg <= ram_rdata;
                    if (ram_rdata == '0)
                    begin
                        st_reg    <= ST_DISK_FULL;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_A_NXT;
                    end
                end
                S_A_NXT:
                begin
                    state_reg <= S_A_CLR;
                end
                S_A_CLR:
                begin
                    res_reg <= alloc_reg;
                    if (head_cur == '0)
                    begin
                        head_reg[fidx_reg] <= alloc_reg;
                        state_reg          <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_A_WALK;
                    end
                end
                S_A_WALK:
                begin
                    if (walk_live && ram_rdata != '0)
                    begin
                        b_reg     <= ram_rdata;
                        steps_reg <= steps_reg + (BW+1)'(1);
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_WALK:
                begin
                    if (!walk_live || ram_rdata == '0)
                    begin
                        st_reg    <= ST_NOT_IN;
                        state_reg <= S_OUT;
                    end
                    else if (ram_rdata == blk_reg)
                    begin
                        pred_reg  <= b_reg;
                        state_reg <= S_D_RDBLK;
                    end
                    else
                    begin
                        b_reg     <= ram_rdata;
                        steps_reg <= steps_reg + (BW+1)'(1);
                    end
                end
                S_D_RDBLK:
                begin
                    if (action_reg == ACT_NEXT)
                    begin
                        res_reg   <= ram_rdata;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        if (pred_reg == '0)
                        begin
                            head_reg[fidx_reg] <= ram_rdata;
                        end
                        state_reg <= S_D_FREE;
                    end
                end
                S_D_FREE:
                begin
                    state_reg <= S_D_PUSH;
                end
                S_D_PUSH:
                begin
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        status_reg    <= st_reg;
                        result_reg    <= 8'(res_reg);
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign result_block = result_reg;

endmodule
